// ===== rtl/lkv_pkg.sv =====
// lkv_pkg: shared types, sizes and operation codes for the key/value table.
// No dependencies; used by lkv_ctrl and linear_key_value_table.
`default_nettype none
package lkv_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 64;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               is_full;
    logic               is_empty;
    logic               dropped;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic                key_we;
    logic                val_we;
    logic [KEY_BITS-1:0] wkey;
    logic [31:0]         wval;
  } ram_ctl_t;

  function automatic logic [4:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+4:0] ext;
    ext = {5'd0, cnt};
    return ext[4:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lkv_ram.sv =====
// lkv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/lkv_ctrl.sv =====
// lkv_ctrl: sequencer that scans the table with one key comparator, shifts
// entries down on delete and holds the result register. Uses lkv_pkg.
`default_nettype none
module lkv_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lkv_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lkv_pkg::out_t                    out_data,
  input  wire logic [31:0]                 miss_value,
  input  wire logic [lkv_pkg::KEY_BITS-1:0] key_rdata,
  input  wire logic [31:0]                 val_rdata,
  output lkv_pkg::ram_ctl_t                ram_ctl
);
  localparam int IDX_W = lkv_pkg::IDX_W;
  localparam int CNT_W = lkv_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  lkv_pkg::in_t       req_r, req_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        rd_r, rd_nxt;
  logic               drop_r, drop_nxt;
  lkv_pkg::out_t      out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]   idx_ext, idx_inc, idx_inc2;
  logic               match, last, load_out;

  assign idx_ext  = CNT_W'(idx_r);
  assign idx_inc  = idx_ext + CNT_W'(1);
  assign idx_inc2 = idx_inc + CNT_W'(1);
  assign match    = (idx_ext < cnt_r) && (key_rdata == req_r.key[lkv_pkg::KEY_BITS-1:0]);
  assign last     = (idx_inc >= cnt_r);
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    rd_nxt         = rd_r;
    drop_nxt       = drop_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_ctl.raddr  = '0;
    ram_ctl.waddr  = idx_r;
    ram_ctl.key_we = 1'b0;
    ram_ctl.val_we = 1'b0;
    ram_ctl.wkey   = req_r.key[lkv_pkg::KEY_BITS-1:0];
    ram_ctl.wval   = req_r.value;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_ctl.raddr = IDX_W'(idx_inc);
        if (match || last) begin
          found_nxt = match;
          rd_nxt    = miss_value;
          drop_nxt  = 1'b0;
          state_nxt = S_OUT;
          case (req_r.func)
            lkv_pkg::FUNC_INSERT: begin
              if (cnt_r == CNT_W'(lkv_pkg::CAPACITY)) begin
                drop_nxt = 1'b1;
              end else if (match) begin
                ram_ctl.val_we = 1'b1;
              end else begin
                ram_ctl.waddr  = IDX_W'(cnt_r);
                ram_ctl.key_we = 1'b1;
                ram_ctl.val_we = 1'b1;
                cnt_nxt        = cnt_r + CNT_W'(1);
              end
            end
            lkv_pkg::FUNC_DELETE: begin
              if (match) begin
                state_nxt = S_SHIFT;
              end
            end
            lkv_pkg::FUNC_LOOKUP: begin
              if (match) begin
                rd_nxt = val_rdata;
              end
            end
            default: begin
            end
          endcase
        end else begin
          idx_nxt = IDX_W'(idx_inc);
        end
      end
      S_SHIFT: begin
        ram_ctl.raddr = IDX_W'(idx_inc2);
        if (idx_inc < cnt_r) begin
          ram_ctl.key_we = 1'b1;
          ram_ctl.val_we = 1'b1;
          ram_ctl.wkey   = key_rdata;
          ram_ctl.wval   = val_rdata;
          idx_nxt        = IDX_W'(idx_inc);
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          out_nxt.found       = found_r;
          out_nxt.read_value  = rd_r;
          out_nxt.entry_count = lkv_pkg::count_field(cnt_r);
          out_nxt.is_full     = (cnt_r == CNT_W'(lkv_pkg::CAPACITY));
          out_nxt.is_empty    = (cnt_r == '0);
          out_nxt.dropped     = drop_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    rd_r    <= rd_nxt;
    drop_r  <= drop_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ===== rtl/linear_key_value_table.sv =====
// linear_key_value_table: top level; key and value RAMs, miss value register
// and the sequencer. Uses lkv_pkg, lkv_ram and lkv_ctrl.
//
// Small associative table of up to CAPACITY key/value pairs, densely packed
// in insertion order. Requests are insert/update, delete (later entries shift
// down one slot) and lookup; each gives exactly one result. The block handles
// one request at a time: in_stall is high from the transfer until the result
// is loaded into the output register. A single comparator walks the key RAM
// one entry per cycle (registered read). A request passes through the idle
// state, which takes the transfer, then the scan, which stops at the matching
// slot or, on a miss, at the last entry; on a delete hit, the shift state then
// moves each later pair down one slot and closes; last, the output state loads
// the result when the output register is empty or not stalled. The miss value
// register is written whenever cfg_valid is high; cfg_ready is always high.
`default_nettype none
module linear_key_value_table (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lkv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lkv_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);
  logic [31:0]                   miss_value_r;
  logic [lkv_pkg::KEY_BITS-1:0]  key_rdata;
  logic [31:0]                   val_rdata;
  lkv_pkg::ram_ctl_t             ram_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_value_r <= '0;
    end else if (cfg_valid) begin
      miss_value_r <= cfg_data;
    end
  end

  lkv_ram #(
    .WIDTH (lkv_pkg::KEY_BITS),
    .DEPTH (lkv_pkg::CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_ctl.key_we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wkey),
    .raddr (ram_ctl.raddr),
    .rdata (key_rdata)
  );

  lkv_ram #(
    .WIDTH (32),
    .DEPTH (lkv_pkg::CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_ctl.val_we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wval),
    .raddr (ram_ctl.raddr),
    .rdata (val_rdata)
  );

  lkv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .miss_value (miss_value_r),
    .key_rdata  (key_rdata),
    .val_rdata  (val_rdata),
    .ram_ctl    (ram_ctl)
  );
endmodule
`default_nettype wire
